// ===== hw/rtl/gnsl_pkg.sv =====
// Shared constants, types and helpers for the nearest grid sample lookup.
// Used by gnsl_axis, the top level and the bench; depends on nothing.
`default_nettype none
package gnsl_pkg;
	localparam int MAX_COLS  = 64;
	localparam int MAX_ROWS  = 64;
	localparam int FRAC_BITS = 16;
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int IDX_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int ADDR_W    = ROW_W + COL_W;
	localparam int DEPTH     = MAX_ROWS * MAX_COLS;
	localparam int VAL_W     = 32;
	localparam int SP_W      = 31;
	localparam int CNT_W     = 7;
	localparam int DW        = 40;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_X_MIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_MAX     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MAX     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPACING   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd6;

	localparam logic [VAL_W-1:0] RST_BOUND_HI = VAL_W'(64) << FRAC_BITS;
	localparam logic [SP_W-1:0]  RST_SPACING  = SP_W'(1) << FRAC_BITS;
	localparam logic [CNT_W-1:0] MAX_COLS_C   = CNT_W'(MAX_COLS);
	localparam logic [CNT_W-1:0] MAX_ROWS_C   = CNT_W'(MAX_ROWS);

	typedef logic signed [DW-1:0] coord_t;

	typedef struct packed {
		logic init;
		logic step;
		logic first;
	} axis_ctrl_t;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n,
			input logic [CNT_W-1:0] top);
		logic [CNT_W-1:0] r;
		if (n == '0) begin
			r = CNT_W'(1);
		end else if (n > top) begin
			r = top;
		end else begin
			r = n;
		end
		return r;
	endfunction

	function automatic coord_t sext_val(input logic [VAL_W-1:0] v);
		return {{(DW-VAL_W){v[VAL_W-1]}}, v};
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/gnsl_axis.sv =====
// One axis of the nearest-node search: running offset, distance compare, best index.
// Depends on gnsl_pkg.
`default_nettype none
module gnsl_axis (
	input  wire                         clk,
	input  wire gnsl_pkg::axis_ctrl_t   ctrl,
	input  wire gnsl_pkg::coord_t       init_diff,
	input  wire gnsl_pkg::coord_t       step_diff,
	input  wire [gnsl_pkg::IDX_W-1:0]   idx,
	output logic [gnsl_pkg::IDX_W-1:0]  best_idx
);
	import gnsl_pkg::*;

	coord_t           diff_q;
	logic [DW-1:0]    best_d_q;
	logic [IDX_W-1:0] best_q;
	logic [DW-1:0]    abs_diff;

	assign abs_diff = diff_q[DW-1] ? DW'(-diff_q) : DW'(diff_q);
	assign best_idx = best_q;

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			diff_q <= init_diff;
		end else if (ctrl.step) begin
			diff_q <= diff_q + step_diff;
			if (ctrl.first || abs_diff <= best_d_q) begin
				best_d_q <= abs_diff;
				best_q   <= idx;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/grid_nearest_sample_lookup.sv =====
// Top level of the nearest grid sample lookup: registers, sequencer, grid memory.
// Depends on gnsl_pkg and gnsl_axis.
//
// Usage:
// The input channel (in_valid / in_stall) carries load and query items. A load
// (req_type 0) writes load_value at load_row, load_col without a stall; it
// gives no result. A query (req_type 1) is checked against the bounds; inside,
// both axes are searched together, one column and one row centre per cycle
// through a shared subtract/compare unit per axis, then the grid memory read
// port is used once. A query holds the input channel through setup, search,
// read and done; an out-of-bounds query through setup and done only. The
// result is offered once the query is done and the output register is free.
// The output channel (out_valid / out_stall) is backed by its own register, so
// loads and the next query are taken while a result waits. A finished query
// holds in its last step until the output register is free.
// Reset clears the sequencer and output valid, and sets configuration defaults;
// the grid memory is undefined until written. The user must write configuration
// through cfg_we / cfg_index / cfg_data while the block is idle; nothing checks it.
`default_nettype none
module grid_nearest_sample_lookup (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire  [gnsl_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [gnsl_pkg::VAL_W-1:0]            cfg_data,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire                                   req_type,
	input  wire  [gnsl_pkg::ROW_W-1:0]            load_row,
	input  wire  [gnsl_pkg::COL_W-1:0]            load_col,
	input  wire  signed [gnsl_pkg::VAL_W-1:0]     load_value,
	input  wire  signed [gnsl_pkg::VAL_W-1:0]     point_x,
	input  wire  signed [gnsl_pkg::VAL_W-1:0]     point_y,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic                                  in_bounds,
	output logic signed [gnsl_pkg::VAL_W-1:0]     sample_value,
	output logic [gnsl_pkg::COL_W-1:0]            nearest_col,
	output logic [gnsl_pkg::ROW_W-1:0]            nearest_row
);
	import gnsl_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SETUP  = 3'd1;
	localparam logic [2:0] ST_SEARCH = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic signed [VAL_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic [SP_W-1:0]         spacing_q;
	logic [CNT_W-1:0]        cols_q, rows_q;

	logic [2:0]              state_q;
	logic [IDX_W-1:0]        cnt_q;
	logic signed [VAL_W-1:0] px_q, py_q;
	logic                    inb_q;

	logic [VAL_W-1:0]        grid_mem_q [DEPTH];
	logic [VAL_W-1:0]        rd_data_q;

	logic                    out_valid_q;
	logic                    out_inb_q;
	logic [VAL_W-1:0]        out_value_q;
	logic [COL_W-1:0]        out_col_q;
	logic [ROW_W-1:0]        out_row_q;

	logic                    in_xfer, out_free, inb;
	logic [CNT_W-1:0]        ncols, nrows, nmax;
	logic [IDX_W-1:0]        last_idx;
	coord_t                  half, sp_ext, x_init, y_init;
	axis_ctrl_t              ctrl_x, ctrl_y;
	logic [IDX_W-1:0]        best_c, best_r;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign ncols    = clamp_count(cols_q, MAX_COLS_C);
	assign nrows    = clamp_count(rows_q, MAX_ROWS_C);
	assign nmax     = (ncols > nrows) ? ncols : nrows;
	assign last_idx = IDX_W'(nmax - CNT_W'(1));

	assign inb = (x_min_q <= px_q) && (px_q <= x_max_q) &&
		(y_min_q <= py_q) && (py_q <= y_max_q);

	assign half   = coord_t'({1'b0, spacing_q[SP_W-1:1]});
	assign sp_ext = coord_t'(spacing_q);
	assign x_init = sext_val(x_min_q) + half - sext_val(px_q);
	assign y_init = sext_val(y_max_q) - half - sext_val(py_q);

	always_comb begin
		ctrl_x.init  = (state_q == ST_SETUP);
		ctrl_x.step  = (state_q == ST_SEARCH) && ({1'b0, cnt_q} < ncols);
		ctrl_x.first = (cnt_q == '0);
		ctrl_y.init  = ctrl_x.init;
		ctrl_y.step  = (state_q == ST_SEARCH) && ({1'b0, cnt_q} < nrows);
		ctrl_y.first = ctrl_x.first;
	end

	gnsl_axis u_axis_x (
		.clk       (clk),
		.ctrl      (ctrl_x),
		.init_diff (x_init),
		.step_diff (sp_ext),
		.idx       (cnt_q),
		.best_idx  (best_c)
	);

	gnsl_axis u_axis_y (
		.clk       (clk),
		.ctrl      (ctrl_y),
		.init_diff (y_init),
		.step_diff (-sp_ext),
		.idx       (cnt_q),
		.best_idx  (best_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q   <= '0;
			x_max_q   <= RST_BOUND_HI;
			y_min_q   <= '0;
			y_max_q   <= RST_BOUND_HI;
			spacing_q <= RST_SPACING;
			cols_q    <= MAX_COLS_C;
			rows_q    <= MAX_ROWS_C;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_MIN:     x_min_q   <= cfg_data;
				REG_X_MAX:     x_max_q   <= cfg_data;
				REG_Y_MIN:     y_min_q   <= cfg_data;
				REG_Y_MAX:     y_max_q   <= cfg_data;
				REG_SPACING:   spacing_q <= cfg_data[SP_W-1:0];
				REG_GRID_COLS: cols_q    <= cfg_data[CNT_W-1:0];
				REG_GRID_ROWS: rows_q    <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && req_type) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					cnt_q   <= '0;
					state_q <= inb ? ST_SEARCH : ST_DONE;
				end
				ST_SEARCH: begin
					if (cnt_q == last_idx) begin
						state_q <= ST_READ;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				ST_READ: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			px_q <= point_x;
			py_q <= point_y;
		end
		if (state_q == ST_SETUP) begin
			inb_q <= inb;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && !req_type) begin
			grid_mem_q[{load_row, load_col}] <= load_value;
		end
		if (state_q == ST_READ) begin
			rd_data_q <= grid_mem_q[{best_r[ROW_W-1:0], best_c[COL_W-1:0]}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_inb_q   <= inb_q;
			out_value_q <= inb_q ? rd_data_q : '0;
			out_col_q   <= inb_q ? best_c[COL_W-1:0] : '0;
			out_row_q   <= inb_q ? best_r[ROW_W-1:0] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign in_bounds    = out_inb_q;
	assign sample_value = out_value_q;
	assign nearest_col  = out_col_q;
	assign nearest_row  = out_row_q;
endmodule
`default_nettype wire

// ===== hw/rtl/gnsl_checker.sv =====
// Port-level checks for the nearest grid sample lookup, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module gnsl_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        req_type,
	input wire        out_valid,
	input wire        out_stall,
	input wire        in_bounds,
	input wire [31:0] sample_value,
	input wire [5:0]  nearest_col,
	input wire [5:0]  nearest_row
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_bounds |-> sample_value == 32'd0 && nearest_col == 6'd0 &&
			nearest_row == 6'd0)
		else $error("out-of-bounds result carries non-zero fields");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && req_type |=> in_stall)
		else $error("input taken during query search");

	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && req_type && !out_valid |=> !out_valid)
		else $error("result appeared one cycle after query transfer");
endmodule

bind grid_nearest_sample_lookup gnsl_checker u_gnsl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.req_type     (req_type),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.in_bounds    (in_bounds),
	.sample_value (sample_value),
	.nearest_col  (nearest_col),
	.nearest_row  (nearest_row)
);
`default_nettype wire

// ===== bench/tb_grid_nearest_sample_lookup.sv =====
// Self-checking bench for grid_nearest_sample_lookup: directed, extreme-register and random
// grid lookups, checked against a behavioural predictor of the block kept in this file.
// Depends on gnsl_pkg and the block's RTL.
module tb_grid_nearest_sample_lookup;
	import gnsl_pkg::*;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
	localparam int SETTLE_CYCLES = 80;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] value;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} lookup_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 req_type;
	logic [ROW_W-1:0]     load_row;
	logic [COL_W-1:0]     load_col;
	logic [VAL_W-1:0]     load_value;
	logic [VAL_W-1:0]     point_x;
	logic [VAL_W-1:0]     point_y;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 in_bounds;
	logic [VAL_W-1:0]     sample_value;
	logic [COL_W-1:0]     nearest_col;
	logic [ROW_W-1:0]     nearest_row;

	logic signed [VAL_W-1:0] bound_x_lo, bound_x_hi, bound_y_lo, bound_y_hi;
	logic [SP_W-1:0]         node_pitch;
	logic [CNT_W-1:0]        col_count, row_count;
	logic [VAL_W-1:0]        grid_mem [DEPTH];
	bit                      node_loaded [DEPTH];
	lookup_t                 pending_lookups [$];

	int gap_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int mismatches = 0;

	grid_nearest_sample_lookup uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .load_row(load_row), .load_col(load_col),
		.load_value(load_value), .point_x(point_x), .point_y(point_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.in_bounds(in_bounds), .sample_value(sample_value),
		.nearest_col(nearest_col), .nearest_row(nearest_row)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int eff_count(input logic [CNT_W-1:0] n, input int top);
		if (n == 0)
			return 1;
		if (n > top)
			return top;
		return int'(n);
	endfunction

	function automatic logic [VAL_W-1:0] clip32(input longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[VAL_W-1:0];
	endfunction

	function automatic lookup_t predict_lookup(input logic [VAL_W-1:0] px,
			input logic [VAL_W-1:0] py);
		lookup_t r;
		longint x, y, xl, xh, yl, yh, pitch, half, d, best;
		int nc, nr;
		r = '0;
		x = longint'($signed(px));
		y = longint'($signed(py));
		xl = longint'(bound_x_lo);
		xh = longint'(bound_x_hi);
		yl = longint'(bound_y_lo);
		yh = longint'(bound_y_hi);
		if (x < xl || x > xh || y < yl || y > yh)
			return r;
		pitch = longint'(node_pitch);
		half = pitch >>> 1;
		nc = eff_count(col_count, MAX_COLS);
		nr = eff_count(row_count, MAX_ROWS);
		best = xl + half - x;
		best = (best < 0) ? -best : best;
		for (int i = 0; i < nc; i++) begin
			d = xl + half + longint'(i) * pitch - x;
			d = (d < 0) ? -d : d;
			if (d <= best) begin
				best = d;
				r.col = COL_W'(i);
			end
		end
		best = yh - half - y;
		best = (best < 0) ? -best : best;
		for (int j = 0; j < nr; j++) begin
			d = yh - half - longint'(j) * pitch - y;
			d = (d < 0) ? -d : d;
			if (d <= best) begin
				best = d;
				r.row = ROW_W'(j);
			end
		end
		r.hit = 1'b1;
		r.value = grid_mem[{r.row, r.col}];
		return r;
	endfunction

	function automatic longint pick_offset(input longint pitch);
		longint off;
		case ($urandom_range(3))
			0: off = 0;
			1: off = ($urandom_range(1) != 0) ? (pitch >>> 1) : -(pitch >>> 1);
			2: off = longint'(int'($urandom)) % (pitch + 1);
			default: off = longint'($urandom_range(6)) - 3;
		endcase
		return off;
	endfunction

	task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
			input logic [VAL_W-1:0] want);
		if (mismatches < 50)
			$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		lookup_t want;
		if (out_valid === 1'b1 && !out_stall) begin
			if (pending_lookups.size() == 0) begin
				report_mismatch("result with nothing expected", sample_value, '0);
			end else begin
				want = pending_lookups.pop_front();
				if (in_bounds !== want.hit)
					report_mismatch("in_bounds", VAL_W'(in_bounds), VAL_W'(want.hit));
				if (sample_value !== want.value)
					report_mismatch("sample_value", sample_value, want.value);
				if (nearest_col !== want.col)
					report_mismatch("nearest_col", VAL_W'(nearest_col), VAL_W'(want.col));
				if (nearest_row !== want.row)
					report_mismatch("nearest_row", VAL_W'(nearest_row), VAL_W'(want.row));
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall = 1'b1;
			hold_cycles--;
		end else begin
			out_stall = ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_item(input logic kind, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [VAL_W-1:0] value,
			input logic [VAL_W-1:0] px, input logic [VAL_W-1:0] py);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		req_type = kind;
		load_row = row;
		load_col = col;
		load_value = value;
		point_x = px;
		point_y = py;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic load_node(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
			input logic [VAL_W-1:0] value);
		send_item(REQ_LOAD, row, col, value, $urandom, $urandom);
		grid_mem[{row, col}] = value;
		node_loaded[{row, col}] = 1'b1;
	endtask

	// A node is never read before a load has written it.
	task automatic query_point(input logic [VAL_W-1:0] px, input logic [VAL_W-1:0] py);
		lookup_t want;
		want = predict_lookup(px, py);
		if (want.hit && !node_loaded[{want.row, want.col}]) begin
			load_node(want.row, want.col, $urandom);
			want = predict_lookup(px, py);
		end
		send_item(REQ_QUERY, $urandom, $urandom, $urandom, px, py);
		pending_lookups.push_back(want);
	endtask

	task automatic query_near_node();
		longint pitch, half, cx, cy;
		int i, j;
		pitch = longint'(node_pitch);
		half = pitch >>> 1;
		i = $urandom_range(eff_count(col_count, MAX_COLS));
		j = $urandom_range(eff_count(row_count, MAX_ROWS));
		cx = longint'(bound_x_lo) + half + longint'(i) * pitch + pick_offset(pitch);
		cy = longint'(bound_y_hi) - half - longint'(j) * pitch + pick_offset(pitch);
		query_point(clip32(cx), clip32(cy));
	endtask

	task automatic query_inside();
		logic [63:0] rnd_x, rnd_y;
		longint span_x, span_y;
		rnd_x = {$urandom, $urandom};
		rnd_y = {$urandom, $urandom};
		span_x = longint'(bound_x_hi) - longint'(bound_x_lo);
		span_y = longint'(bound_y_hi) - longint'(bound_y_lo);
		span_x = (span_x < 0) ? 0 : span_x;
		span_y = (span_y < 0) ? 0 : span_y;
		query_point(clip32(longint'(bound_x_lo) + longint'(rnd_x % 64'(span_x + 1))),
			clip32(longint'(bound_y_lo) + longint'(rnd_y % 64'(span_y + 1))));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [VAL_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (index)
			REG_X_MIN:     bound_x_lo = data;
			REG_X_MAX:     bound_x_hi = data;
			REG_Y_MIN:     bound_y_lo = data;
			REG_Y_MAX:     bound_y_hi = data;
			REG_SPACING:   node_pitch = data[SP_W-1:0];
			REG_GRID_COLS: col_count = data[CNT_W-1:0];
			REG_GRID_ROWS: row_count = data[CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_grid(input logic [VAL_W-1:0] xl, input logic [VAL_W-1:0] xh,
			input logic [VAL_W-1:0] yl, input logic [VAL_W-1:0] yh,
			input logic [VAL_W-1:0] pitch, input logic [VAL_W-1:0] cols,
			input logic [VAL_W-1:0] rows);
		write_reg(REG_X_MIN, xl);
		write_reg(REG_X_MAX, xh);
		write_reg(REG_Y_MIN, yl);
		write_reg(REG_Y_MAX, yh);
		write_reg(REG_SPACING, pitch);
		write_reg(REG_GRID_COLS, cols);
		write_reg(REG_GRID_ROWS, rows);
	endtask

	// Drain every result, then let a trailing load finish.
	task automatic settle_block();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 47; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 47; end
			default: begin gap_pct = 20; stall_pct = 20; end
		endcase
	endtask

	task automatic test_default_grid();
		load_node(6'd0, 6'd0, 32'h7FFF_FFFF);
		load_node(6'd63, 6'd63, 32'h8000_0000);
		load_node(6'd0, 6'd63, 32'h0000_0000);
		load_node(6'd63, 6'd0, 32'hFFFF_FFFF);
		load_node(6'd21, 6'd42, 32'h5555_AAAA);
		query_point(32'h0040_0000, 32'h0040_0000);
		query_point(32'h0000_0000, 32'h0000_0000);
		query_point(32'h0000_0000, 32'h0040_0000);
		query_point(32'h0040_0000, 32'h0000_0000);
		query_point(32'h002A_8000, 32'h002A_8000);
		// midway between two centres on both axes: the later index wins
		query_point(32'h0001_0000, 32'h003F_0000);
		query_point(32'hFFFF_FFFF, 32'h0005_0000);
		query_point(32'h0005_0000, 32'h0040_0001);
		query_point(32'h8000_0000, 32'h0001_0000);
		query_point(32'h0001_0000, 32'h7FFF_FFFF);
		query_point(32'h7FFF_FFFF, 32'h8000_0000);
	endtask

	task automatic test_register_extremes();
		for (int p = 0; p < 5; p++) begin
			settle_block();
			set_idling(p % 4);
			case (p)
				0: apply_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
					32'hFFFF_FFFF, 32'd64, 32'd64);
				1: apply_grid(32'hFF9C_0000, 32'h0064_0000, 32'hFF9C_0000, 32'h0064_0000,
					32'h8000_0000, 32'hFFFF_FF80, 32'h0000_007F);
				2: apply_grid(32'h0064_0000, 32'hFF9C_0000, 32'h0000_0000, 32'h0010_0000,
					32'h0001_0000, 32'd8, 32'd8);
				3: apply_grid(32'hFFF8_0000, 32'h0008_0000, 32'hFFF8_0000, 32'h0008_0000,
					32'd1, 32'd1, 32'd1);
				default: apply_grid(32'h0000_0000, 32'h0000_0040, 32'h0000_0000,
					32'h0000_0040, 32'd1, 32'd127, 32'd0);
			endcase
			repeat (20) query_near_node();
			repeat (4) query_inside();
			query_point($urandom, $urandom);
		end
	endtask

	task automatic test_output_hold_off();
		settle_block();
		set_idling(0);
		apply_grid(32'h0000_0000, 32'h0008_0000, 32'h0000_0000, 32'h0008_0000,
			32'h0001_0000, 32'd8, 32'd8);
		@(posedge clk);
		hold_cycles = 500;
		repeat (30) query_near_node();
	endtask

	task automatic random_grid_setup();
		logic [VAL_W-1:0] pitch_w, cols_w, rows_w;
		longint pitch, xl, xh, yl, yh, swap;
		case ($urandom_range(5))
			0: pitch_w = 32'h0001_0000;
			1: pitch_w = 32'($urandom_range(1, 4096)) << 1;
			2: pitch_w = (32'($urandom_range(2000)) << 1) | 32'd1;
			3: pitch_w = $urandom_range(1, 32'h7FFF_FFFF);
			4: pitch_w = 32'd1 << $urandom_range(30);
			default: pitch_w = $urandom_range(3);
		endcase
		cols_w = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(1, 12);
		rows_w = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(1, 12);
		pitch = longint'(pitch_w[SP_W-1:0]);
		xl = longint'(int'($urandom)) >>> $urandom_range(4, 20);
		xh = xl + longint'(eff_count(cols_w[CNT_W-1:0], MAX_COLS)) * pitch
			+ pick_offset(pitch);
		yh = longint'(int'($urandom)) >>> $urandom_range(4, 20);
		yl = yh - longint'(eff_count(rows_w[CNT_W-1:0], MAX_ROWS)) * pitch
			- pick_offset(pitch);
		if ($urandom_range(9) == 0) begin
			swap = xl;
			xl = xh;
			xh = swap;
		end
		apply_grid(clip32(xl), clip32(xh), clip32(yl), clip32(yh), pitch_w, cols_w, rows_w);
	endtask

	task automatic test_random_grids();
		int pick;
		for (int p = 0; p < 12; p++) begin
			settle_block();
			set_idling(p % 4);
			random_grid_setup();
			repeat (95) begin
				pick = $urandom_range(99);
				if (pick < 65)
					query_near_node();
				else if (pick < 80)
					load_node($urandom, $urandom, $urandom);
				else if (pick < 88)
					query_inside();
				else
					query_point($urandom, $urandom);
			end
		end
	endtask

	initial begin
		int drain;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_LOAD;
		load_row = '0;
		load_col = '0;
		load_value = '0;
		point_x = '0;
		point_y = '0;
		bound_x_lo = '0;
		bound_x_hi = RST_BOUND_HI;
		bound_y_lo = '0;
		bound_y_hi = RST_BOUND_HI;
		node_pitch = RST_SPACING;
		col_count = MAX_COLS_C;
		row_count = MAX_ROWS_C;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_grid();
		test_register_extremes();
		test_output_hold_off();
		test_random_grids();

		@(negedge clk);
		in_valid = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		drain = 0;
		while (pending_lookups.size() != 0 && drain < 100000) begin
			@(posedge clk);
			drain++;
		end
		repeat (100) @(posedge clk);
		if (pending_lookups.size() != 0)
			report_mismatch("results never arrived", pending_lookups.size(), '0);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
